// ----- rtl/core/grtb_pkg.sv -----
`timescale 1ns / 1ps
// Package for the grouped repeat timer bank: command and event codes,
// the front-to-back command record and default parameter values.
package grtb_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int GROUP_COUNT_DEF = 8;
    localparam int TIME_BITS_DEF   = 32;
    localparam int CMD_DEPTH       = 2;

    typedef enum logic [2:0] {
        K_TICK     = 3'd0,
        K_CREATE   = 3'd1,
        K_CANCEL   = 3'd2,
        K_GPAUSE   = 3'd3,
        K_GRESUME  = 3'd4,
        K_GCLEAR   = 3'd5,
        K_TPAUSE   = 3'd6,
        K_TRESUME  = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        EV_DONE      = 3'd0,
        EV_REPEATED  = 3'd1,
        EV_COMPLETED = 3'd2,
        EV_REMOVED   = 3'd3,
        EV_CREATED   = 3'd4,
        EV_FULL      = 3'd5
    } t_event;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] delta;
        logic [31:0] duration;
        logic [15:0] repeat_count;
        logic        forever_req;
        logic [2:0]  group;
        logic [3:0]  timer_id;
        logic        notify_removed;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_EMIT = 2'd2,
        S_DONE = 2'd3
    } t_state;

endpackage

// ----- rtl/core/grtb_cmd_fifo.sv -----
`timescale 1ns / 1ps
// Short command queue between the front end and the slot engine.
// Depends on grtb_pkg for the command record.
module grtb_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  grtb_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output grtb_pkg::t_cmd o_cmd
);
    localparam int D = grtb_pkg::CMD_DEPTH;
    grtb_pkg::t_cmd r_mem [D];
    logic [$clog2(D)-1:0] r_wp, r_rp;
    logic [$clog2(D):0]   r_cnt;
    logic wr, rd;

    assign o_ready = (r_cnt != ($clog2(D)+1)'(D));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + ($clog2(D)+1)'(wr) - ($clog2(D)+1)'(rd);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ($clog2(D)+1)'(D)) else $error("queue count overflow");
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd |-> r_cnt != '0) else $error("read of empty queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> r_cnt == $past(r_cnt) + 1'b1) else $error("count step");
endmodule

// ----- rtl/core/grtb_engine.sv -----
`timescale 1ns / 1ps
// Slot engine: holds the timer table and carries out one command at a time,
// walking slots one per cycle for a tick (while the output is free) or a group clear. Depends on grtb_pkg.
module grtb_engine #(
    parameter int TIMER_SLOTS = grtb_pkg::TIMER_SLOTS_DEF,
    parameter int GROUP_COUNT = grtb_pkg::GROUP_COUNT_DEF,
    parameter int TIME_BITS   = grtb_pkg::TIME_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  grtb_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_event_res,
    output logic [3:0]     o_event_timer,
    output logic           o_last
);
    localparam int SB = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int GB = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    logic [TIMER_SLOTS-1:0] r_live, n_live;
    logic [TIME_BITS-1:0]   r_elapsed [TIMER_SLOTS];
    logic [TIME_BITS-1:0]   r_period  [TIMER_SLOTS];
    logic [16:0]            r_reps    [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] r_forever, r_tpause;
    logic [2:0]             r_tgroup  [TIMER_SLOTS];
    logic [GROUP_COUNT-1:0] r_gpause;

    grtb_pkg::t_state r_state, n_state;
    grtb_pkg::t_cmd   r_cmd;
    logic [SB:0]      r_idx, n_idx;
    logic             r_ovalid, n_ovalid;
    logic [2:0]       r_ores, n_ores;
    logic [3:0]       r_otim, n_otim;
    logic             r_olast, n_olast;
    logic             r_pend_cmp, n_pend_cmp;

    logic [SB-1:0] si;
    logic [SB-1:0] tid;
    logic [GB-1:0] gi, tg;
    logic          tid_ok, grp_ok, tg_ok;
    logic [TIME_BITS:0] sum;
    logic [TIME_BITS-1:0] e_new;
    logic active, expire, out_free, fin;
    logic wr_tick, wr_create;
    logic [SB-1:0] free_idx;
    logic          free_any;

    assign si  = r_idx[SB-1:0];
    assign tid = SB'(r_cmd.timer_id);
    assign gi  = GB'(r_cmd.group);
    assign tid_ok = {28'd0, r_cmd.timer_id} < TIMER_SLOTS;
    assign grp_ok = {29'd0, r_cmd.group} < GROUP_COUNT;
    assign tg  = GB'(r_tgroup[si]);
    assign tg_ok = {29'd0, r_tgroup[si]} < GROUP_COUNT;
    assign sum = {1'b0, r_elapsed[si]} + (TIME_BITS+1)'(r_cmd.delta);
    assign e_new = sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
    assign active = r_live[si] && !r_tpause[si] && !(tg_ok && r_gpause[tg]);
    assign expire = e_new >= r_period[si];
    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int k = TIMER_SLOTS - 1; k >= 0; k--) begin
            if (!r_live[k]) begin
                free_idx = SB'(k);
                free_any = 1'b1;
            end
        end
    end

    assign o_cmd_ready = (r_state == grtb_pkg::S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_event_res = r_ores;
    assign o_event_timer = r_otim;
    assign o_last = r_olast;

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_live = r_live;
        n_ovalid = r_ovalid && !i_ready;
        n_ores = r_ores;
        n_otim = r_otim;
        n_olast = r_olast;
        n_pend_cmp = r_pend_cmp;
        wr_tick = 1'b0;
        wr_create = 1'b0;
        fin = 1'b0;
        case (r_state)
            grtb_pkg::S_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    n_idx = '0;
                    n_state = (i_cmd.kind == grtb_pkg::K_TICK ||
                               i_cmd.kind == grtb_pkg::K_GCLEAR)
                              ? grtb_pkg::S_SCAN : grtb_pkg::S_DONE;
                end
            end
            grtb_pkg::S_SCAN: begin
                if (r_idx == (SB+1)'(TIMER_SLOTS)) begin
                    n_state = grtb_pkg::S_DONE;
                end else if (r_cmd.kind == grtb_pkg::K_GCLEAR) begin
                    if (r_tgroup[si] == r_cmd.group) n_live[si] = 1'b0;
                    n_idx = r_idx + 1'b1;
                end else if (out_free) begin
                    n_idx = r_idx + 1'b1;
                    if (active) begin
                        wr_tick = 1'b1;
                        if (expire) begin
                            n_ovalid = 1'b1;
                            n_ores = grtb_pkg::EV_REPEATED;
                            n_otim = 4'(r_idx);
                            n_olast = 1'b0;
                            if (!r_forever[si] && r_reps[si] <= 17'd1) begin
                                n_live[si] = 1'b0;
                                n_pend_cmp = 1'b1;
                                n_state = grtb_pkg::S_EMIT;
                            end
                        end
                    end
                end
            end
            grtb_pkg::S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ores = grtb_pkg::EV_COMPLETED;
                    n_otim = 4'(r_idx - 1'b1);
                    n_olast = 1'b0;
                    n_pend_cmp = 1'b0;
                    n_state = grtb_pkg::S_SCAN;
                end
            end
            default: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_olast = 1'b1;
                    n_ores = grtb_pkg::EV_DONE;
                    n_otim = '0;
                    fin = 1'b1;
                    n_state = grtb_pkg::S_IDLE;
                    case (r_cmd.kind)
                        grtb_pkg::K_CREATE: begin
                            if (free_any) begin
                                wr_create = 1'b1;
                                n_live[free_idx] = 1'b1;
                                n_ores = grtb_pkg::EV_CREATED;
                                n_otim = 4'(free_idx);
                            end else begin
                                n_ores = grtb_pkg::EV_FULL;
                            end
                        end
                        grtb_pkg::K_CANCEL: begin
                            if (tid_ok && r_live[tid]) begin
                                n_live[tid] = 1'b0;
                                if (r_cmd.notify_removed) begin
                                    n_ores = grtb_pkg::EV_REMOVED;
                                    n_otim = r_cmd.timer_id;
                                    n_olast = 1'b0;
                                    fin = 1'b0;
                                    n_state = grtb_pkg::S_DONE;
                                    n_live[tid] = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == grtb_pkg::S_IDLE && i_cmd_valid && o_cmd_ready) begin
            r_cmd <= i_cmd;
        end
        if (!i_rst_n) begin
            for (int k = 0; k < TIMER_SLOTS; k++) r_elapsed[k] <= '0;
        end else begin
            if (wr_tick) begin
                if (expire) begin
                    r_elapsed[si] <= '0;
                    if (!r_forever[si] && r_reps[si] > 17'd1) begin
                        r_reps[si] <= r_reps[si] - 1'b1;
                    end
                end else begin
                    r_elapsed[si] <= e_new;
                end
            end
            if (wr_create) begin
                r_elapsed[free_idx] <= '0;
                r_period[free_idx]  <= (TIME_BITS >= 32) ? TIME_BITS'(r_cmd.duration)
                    : ((r_cmd.duration > 32'(TMAX)) ? TMAX : TIME_BITS'(r_cmd.duration));
                r_reps[free_idx]    <= {1'b0, r_cmd.repeat_count};
                r_forever[free_idx] <= r_cmd.forever_req;
                r_tgroup[free_idx]  <= r_cmd.group;
                r_tpause[free_idx]  <= 1'b0;
            end
        end
        if (r_state == grtb_pkg::S_DONE && out_free && tid_ok) begin
            if (r_cmd.kind == grtb_pkg::K_TPAUSE) r_tpause[tid] <= 1'b1;
            if (r_cmd.kind == grtb_pkg::K_TRESUME) r_tpause[tid] <= 1'b0;
        end
        r_ores <= n_ores;
        r_otim <= n_otim;
        r_olast <= n_olast;
        r_idx <= n_idx;
        if (!i_rst_n) begin
            r_state <= grtb_pkg::S_IDLE;
            r_live <= '0;
            r_gpause <= '0;
            r_ovalid <= 1'b0;
            r_pend_cmp <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live <= n_live;
            r_ovalid <= n_ovalid;
            r_pend_cmp <= n_pend_cmp;
            if (fin && grp_ok && r_cmd.kind == grtb_pkg::K_GPAUSE) r_gpause[gi] <= 1'b1;
            if (fin && grp_ok && r_cmd.kind == grtb_pkg::K_GRESUME) r_gpause[gi] <= 1'b0;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> r_ovalid && $stable(r_ores) && $stable(r_otim))
        else $error("result changed while stalled");
    a_emit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == grtb_pkg::S_EMIT) |-> r_pend_cmp) else $error("emit without pending");
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == grtb_pkg::S_SCAN) |-> r_cmd.kind == grtb_pkg::K_TICK
        || r_cmd.kind == grtb_pkg::K_GCLEAR) else $error("scan on wrong kind");
endmodule

// ----- rtl/core/grouped_repeat_timer_bank.sv -----
`timescale 1ns / 1ps
// Top level of the grouped repeat timer bank: command queue and slot engine.
// Depends on grtb_pkg, grtb_cmd_fifo, grtb_engine.
//
// Use: commands enter on the i_valid/o_ready channel; each transfer yields
// one or more events on the o_valid/i_ready channel, the final one with
// o_last set. A tick walks every slot, one slot per cycle while the receiver
// does not stall, with an extra emit step per completed timer. A two-entry
// queue lets new commands be taken while the engine works. When the receiver
// stalls, the engine halts with the pending event held steady. Synchronous
// reset frees all slots, clears elapsed times and group pauses, and empties
// the queue.
module grouped_repeat_timer_bank #(
    parameter int TIMER_SLOTS = grtb_pkg::TIMER_SLOTS_DEF,
    parameter int GROUP_COUNT = grtb_pkg::GROUP_COUNT_DEF,
    parameter int TIME_BITS   = grtb_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_delta,
    input  logic [31:0] i_duration,
    input  logic [15:0] i_repeat_count,
    input  logic        i_forever_req,
    input  logic [2:0]  i_group,
    input  logic [3:0]  i_timer_id,
    input  logic        i_notify_removed,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_res,
    output logic [3:0]  o_event_timer,
    output logic        o_last
);
    grtb_pkg::t_cmd in_cmd, q_cmd;
    logic q_valid, q_ready;

    always_comb begin
        in_cmd.kind = grtb_pkg::t_kind'(i_kind);
        in_cmd.delta = i_delta;
        in_cmd.duration = i_duration;
        in_cmd.repeat_count = i_repeat_count;
        in_cmd.forever_req = i_forever_req;
        in_cmd.group = i_group;
        in_cmd.timer_id = i_timer_id;
        in_cmd.notify_removed = i_notify_removed;
    end

    grtb_cmd_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_cmd(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    grtb_engine #(
        .TIMER_SLOTS(TIMER_SLOTS), .GROUP_COUNT(GROUP_COUNT), .TIME_BITS(TIME_BITS)
    ) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(q_valid), .o_cmd_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_event_res(o_event_res), .o_event_timer(o_event_timer), .o_last(o_last)
    );
endmodule

// ----- tb/grouped_repeat_timer_bank_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for grouped_repeat_timer_bank: a directed command table,
// then random command streams, checked event by event against a behavioral timer bank.
// Depends on grtb_pkg and the grouped_repeat_timer_bank RTL.
module grouped_repeat_timer_bank_test;

    localparam int NSLOT = 16;
    localparam int NGRP = 8;
    localparam logic [31:0] TMAX = 32'hFFFF_FFFF;

    typedef struct packed {
        grtb_pkg::t_event ev;
        logic [3:0]       slot;
        logic             last;
    } t_evt;

    typedef struct {
        grtb_pkg::t_kind  kind;
        logic [15:0]      delta;
        logic [31:0]      duration;
        logic [15:0]      reps;
        logic             forever_req;
        logic [2:0]       group;
        logic [3:0]       timer_id;
        logic             notify;
        logic             has_exp;
        grtb_pkg::t_event exp_ev;
        logic [3:0]       exp_slot;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  in_kind = '0;
    logic [15:0] in_delta = '0;
    logic [31:0] in_duration = '0;
    logic [15:0] in_reps = '0;
    logic        in_forever = 1'b0;
    logic [2:0]  in_group = '0;
    logic [3:0]  in_timer_id = '0;
    logic        in_notify = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  out_ev;
    logic [3:0]  out_slot;
    logic        out_last;

    logic        live [NSLOT];
    logic [31:0] elapsed [NSLOT];
    logic [31:0] period [NSLOT];
    logic [16:0] repeats [NSLOT];
    logic        forever_flag [NSLOT];
    logic [2:0]  grp_of [NSLOT];
    logic        tpaused [NSLOT];
    logic [NGRP-1:0] gpaused;

    t_evt pending_events [$];
    int   errors = 0;
    int   events_seen = 0;
    int   cmds_sent = 0;
    bit   hold_off = 1'b0;

    grouped_repeat_timer_bank dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_kind(in_kind), .i_delta(in_delta), .i_duration(in_duration),
        .i_repeat_count(in_reps), .i_forever_req(in_forever), .i_group(in_group),
        .i_timer_id(in_timer_id), .i_notify_removed(in_notify),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_event_res(out_ev), .o_event_timer(out_slot), .o_last(out_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic push_event(input grtb_pkg::t_event ev, input logic [3:0] slot,
                              input logic last);
        t_evt e;
        e.ev = ev;
        e.slot = slot;
        e.last = last;
        pending_events.insert(pending_events.size(), e);
    endtask

    task automatic bank_reset();
        for (int i = 0; i < NSLOT; i++) begin
            live[i] = 1'b0;
            elapsed[i] = '0;
            period[i] = '0;
            repeats[i] = '0;
            forever_flag[i] = 1'b0;
            grp_of[i] = '0;
            tpaused[i] = 1'b0;
        end
        gpaused = '0;
    endtask

    task automatic predict_bank(input t_row r);
        logic [32:0] sum;
        case (r.kind)
            grtb_pkg::K_TICK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (live[i] && !tpaused[i] && !gpaused[grp_of[i]]) begin
                        sum = {1'b0, elapsed[i]} + r.delta;
                        elapsed[i] = sum[32] ? TMAX : sum[31:0];
                        if (elapsed[i] >= period[i]) begin
                            push_event(grtb_pkg::EV_REPEATED, 4'(i), 1'b0);
                            elapsed[i] = '0;
                            if (!forever_flag[i]) begin
                                if (repeats[i] <= 17'd1) begin
                                    repeats[i] = '0;
                                    push_event(grtb_pkg::EV_COMPLETED, 4'(i), 1'b0);
                                    live[i] = 1'b0;
                                end else begin
                                    repeats[i] = repeats[i] - 17'd1;
                                end
                            end
                        end
                    end
                end
            end
            grtb_pkg::K_CREATE: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!live[i]) begin
                        live[i] = 1'b1;
                        elapsed[i] = '0;
                        period[i] = r.duration;
                        repeats[i] = {1'b0, r.reps};
                        forever_flag[i] = r.forever_req;
                        grp_of[i] = r.group;
                        tpaused[i] = 1'b0;
                        push_event(grtb_pkg::EV_CREATED, 4'(i), 1'b1);
                        return;
                    end
                end
                push_event(grtb_pkg::EV_FULL, 4'd0, 1'b1);
                return;
            end
            grtb_pkg::K_CANCEL: begin
                if (live[r.timer_id]) begin
                    live[r.timer_id] = 1'b0;
                    if (r.notify) push_event(grtb_pkg::EV_REMOVED, r.timer_id, 1'b0);
                end
            end
            grtb_pkg::K_GPAUSE: gpaused[r.group] = 1'b1;
            grtb_pkg::K_GRESUME: gpaused[r.group] = 1'b0;
            grtb_pkg::K_GCLEAR: begin
                for (int i = 0; i < NSLOT; i++)
                    if (live[i] && grp_of[i] == r.group) live[i] = 1'b0;
            end
            grtb_pkg::K_TPAUSE: tpaused[r.timer_id] = 1'b1;
            default: tpaused[r.timer_id] = 1'b0;
        endcase
        push_event(grtb_pkg::EV_DONE, 4'd0, 1'b1);
    endtask

    function automatic t_row mk(input grtb_pkg::t_kind k, input logic [15:0] d,
                                input logic [31:0] dur,
                                input logic [15:0] rp, input logic fv, input logic [2:0] g,
                                input logic [3:0] id, input logic nt);
        t_row r;
        r.kind = k;
        r.delta = d;
        r.duration = dur;
        r.reps = rp;
        r.forever_req = fv;
        r.group = g;
        r.timer_id = id;
        r.notify = nt;
        r.has_exp = 1'b0;
        r.exp_ev = grtb_pkg::EV_DONE;
        r.exp_slot = '0;
        return r;
    endfunction

    function automatic t_row mk_exp(input t_row r, input grtb_pkg::t_event ev,
                                    input logic [3:0] s);
        t_row o;
        o = r;
        o.has_exp = 1'b1;
        o.exp_ev = ev;
        o.exp_slot = s;
        return o;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    task automatic send_cmd(input t_row r);
        int n;
        n = gap_len();
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        if (r.has_exp) begin
            predict_bank(r);
            if (pending_events[$].ev !== r.exp_ev || pending_events[$].slot !== r.exp_slot)
            begin
                $display("%0t directed row: expected %0d/%0d, predictor %0d/%0d", $time,
                         r.exp_ev, r.exp_slot, pending_events[$].ev, pending_events[$].slot);
                errors++;
            end
        end else begin
            predict_bank(r);
        end
        in_valid <= 1'b1;
        in_kind <= r.kind;
        in_delta <= r.delta;
        in_duration <= r.duration;
        in_reps <= r.reps;
        in_forever <= r.forever_req;
        in_group <= r.group;
        in_timer_id <= r.timer_id;
        in_notify <= r.notify;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        cmds_sent++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0 && guard < 100_000) begin
            @(posedge clk);
            guard++;
        end
    endtask

    function automatic t_row rand_cmd();
        t_row r;
        int p;
        logic [31:0] dur;
        p = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: dur = $urandom_range(0, 3);
            1: dur = $urandom_range(0, 3000);
            2: dur = $urandom;
            default: dur = $urandom_range(100, 200);
        endcase
        r = mk(grtb_pkg::K_TICK,
               16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200)),
               dur, 16'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 4)),
               1'($urandom), 3'($urandom), 4'($urandom), 1'($urandom));
        if (p < 40) r.kind = grtb_pkg::K_TICK;
        else if (p < 70) r.kind = grtb_pkg::K_CREATE;
        else if (p < 80) r.kind = grtb_pkg::K_CANCEL;
        else r.kind = grtb_pkg::t_kind'($urandom_range(3, 7));
        return r;
    endfunction

    always @(posedge clk) begin
        t_evt e;
        if (rst_n && out_valid && out_ready) begin
            events_seen++;
            if (pending_events.size() == 0) begin
                $display("%0t unexpected event: actual %0d/%0d/%0d", $time,
                         out_ev, out_slot, out_last);
                errors++;
            end else begin
                e = pending_events.pop_front();
                if (out_ev !== e.ev || out_slot !== e.slot || out_last !== e.last) begin
                    $display("%0t event mismatch: expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                             $time, e.ev, e.slot, e.last, out_ev, out_slot, out_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        int stall;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end else if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = gap_len();
            end
        end
    end

    initial begin
        t_row dir [$];
        t_row r;
        bank_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir.insert(dir.size(), mk_exp(mk(grtb_pkg::K_CREATE, 0, 0, 0, 0, 0, 0, 0),
                                      grtb_pkg::EV_CREATED, 4'd0));
        dir.insert(dir.size(), mk(grtb_pkg::K_TICK, 0, 0, 0, 0, 0, 0, 0));
        dir.insert(dir.size(), mk_exp(mk(grtb_pkg::K_CREATE, 0, 32'hFFFF_FFFF, 16'hFFFF,
                                         1, 3'd7, 0, 0), grtb_pkg::EV_CREATED, 4'd0));
        dir.insert(dir.size(), mk_exp(mk(grtb_pkg::K_CREATE, 0, 5, 2, 0, 3'd2, 0, 0),
                                      grtb_pkg::EV_CREATED, 4'd1));
        dir.insert(dir.size(), mk_exp(mk(grtb_pkg::K_CREATE, 0, 1, 0, 1, 3'd2, 0, 0),
                                      grtb_pkg::EV_CREATED, 4'd2));
        dir.insert(dir.size(), mk(grtb_pkg::K_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0));
        dir.insert(dir.size(), mk(grtb_pkg::K_TPAUSE, 0, 0, 0, 0, 0, 4'd2, 0));
        dir.insert(dir.size(), mk(grtb_pkg::K_TICK, 7, 0, 0, 0, 0, 0, 0));
        dir.insert(dir.size(), mk(grtb_pkg::K_TRESUME, 0, 0, 0, 0, 0, 4'd2, 0));
        dir.insert(dir.size(), mk(grtb_pkg::K_GPAUSE, 0, 0, 0, 0, 3'd2, 0, 0));
        dir.insert(dir.size(), mk(grtb_pkg::K_TICK, 1, 0, 0, 0, 0, 0, 0));
        dir.insert(dir.size(), mk(grtb_pkg::K_GRESUME, 0, 0, 0, 0, 3'd2, 0, 0));
        dir.insert(dir.size(), mk(grtb_pkg::K_TPAUSE, 0, 0, 0, 0, 0, 4'd15, 0));
        dir.insert(dir.size(), mk(grtb_pkg::K_TRESUME, 0, 0, 0, 0, 0, 4'd15, 0));
        dir.insert(dir.size(), mk(grtb_pkg::K_CANCEL, 0, 0, 0, 0, 0, 4'd1, 1));
        dir.insert(dir.size(), mk(grtb_pkg::K_CANCEL, 0, 0, 0, 0, 0, 4'd15, 1));
        dir.insert(dir.size(), mk(grtb_pkg::K_CANCEL, 0, 0, 0, 0, 0, 4'd0, 0));
        dir.insert(dir.size(), mk(grtb_pkg::K_GCLEAR, 0, 0, 0, 0, 3'd2, 0, 0));
        for (int i = 0; i < NSLOT; i++)
            dir.insert(dir.size(), mk(grtb_pkg::K_CREATE, 0, 32'd3, 16'd1, 0, 3'(i), 0, 0));
        dir.insert(dir.size(), mk_exp(mk(grtb_pkg::K_CREATE, 0, 1, 1, 0, 0, 0, 0),
                                      grtb_pkg::EV_FULL, 4'd0));
        dir.insert(dir.size(), mk(grtb_pkg::K_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0));
        foreach (dir[i]) send_cmd(dir[i]);
        wait_drained();

        for (int n = 0; n < 160; n++) begin
            if (n == 60) hold_off = 1'b1;
            if (n == 110) wait_drained();
            r = rand_cmd();
            send_cmd(r);
        end
        wait_drained();
        repeat (60) @(posedge clk);
        $display("Sent %0d commands (directed table, random mix, long output stall).",
                 cmds_sent);
        $display("Checked %0d events, %0d left unmatched.", events_seen, pending_events.size());
        if (errors == 0 && pending_events.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
